[rtl/rlb_pkg.sv]
`default_nettype none

package rlb_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int T_BITS       = CHANNEL_BITS + 1;
  localparam int K_BITS       = 2 * CHANNEL_BITS;
  localparam int NUM_BITS     = 3 * CHANNEL_BITS;
  localparam int NUM_CHANNELS = 4;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};
  localparam logic [T_BITS-1:0]       T_ONE  = T_BITS'(256);
  localparam logic [K_BITS-1:0]       W_ONE  = K_BITS'(65280);

  // blend mode codes
  localparam logic [2:0] MODE_LERP  = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_SUB   = 3'd2;
  localparam logic [2:0] MODE_MUL   = 3'd3;
  localparam logic [2:0] MODE_DIV   = 3'd4;
  localparam logic [2:0] MODE_ALPHA = 3'd5;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = T_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRANS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE  = 3'd4;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t dest_red;
    chan_t dest_green;
    chan_t dest_blue;
    chan_t dest_alpha;
    logic  src_present;
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
  } pixel_in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
  } pixel_out_t;

  // per-lane control handed from the top level to each channel
  typedef struct packed {
    logic [2:0] mode;
    logic       pass;
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/rlb_div.sv]
`default_nettype none

// saturating 16 by 8 divider, four quotient bits on each side of one register
module rlb_div (
  input  wire logic                         clk,
  input  wire logic [rlb_pkg::K_BITS-1:0]   num,
  input  wire logic [rlb_pkg::CHANNEL_BITS-1:0] den,
  output logic      [rlb_pkg::CHANNEL_BITS-1:0] quot
);

  localparam int KB = rlb_pkg::K_BITS;
  localparam int CB = rlb_pkg::CHANNEL_BITS;
  localparam int HB = CB / 2;

  logic [KB-1:0] rem_next;
  logic [HB-1:0] qhi_next;
  logic          ovf_next;

  logic [KB-1:0] rem;
  logic [HB-1:0] qhi;
  logic          ovf;
  logic [CB-1:0] den_r;

  logic [HB-1:0] qlo;

  // upper quotient bits
  always_comb begin
    logic [KB-1:0] r;
    logic [KB-1:0] sh;
    r        = num;
    qhi_next = '0;
    ovf_next = (num >= {den, {CB{1'b0}}});
    for (int i = HB - 1; i >= 0; i--) begin
      sh = KB'(den) << (i + HB);
      if (r >= sh) begin
        r = r - sh;
        qhi_next[i] = 1'b1;
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    qhi   <= qhi_next;
    ovf   <= ovf_next;
    den_r <= den;
  end

  // lower quotient bits
  always_comb begin
    logic [KB-1:0] r;
    logic [KB-1:0] sh;
    r   = rem;
    qlo = '0;
    for (int i = HB - 1; i >= 0; i--) begin
      sh = KB'(den_r) << i;
      if (r >= sh) begin
        r = r - sh;
        qlo[i] = 1'b1;
      end
    end
  end

  assign quot = ovf ? rlb_pkg::CH_MAX : {qhi, qlo};

endmodule

`default_nettype wire

[rtl/rlb_chan.sv]
`default_nettype none

// one colour channel: products, linear blends, numerator, divide, select
module rlb_chan (
  input  wire logic                         clk,
  input  wire rlb_pkg::chan_t               d,
  input  wire rlb_pkg::chan_t               s,
  input  wire logic [rlb_pkg::T_BITS-1:0]   t,
  input  wire rlb_pkg::lane_ctl_t           ctl,
  input  wire logic [rlb_pkg::K_BITS-1:0]   w,
  input  wire logic [rlb_pkg::K_BITS-1:0]   wc,
  output rlb_pkg::chan_t                    value
);

  localparam int CB = rlb_pkg::CHANNEL_BITS;
  localparam int TB = rlb_pkg::T_BITS;
  localparam int KB = rlb_pkg::K_BITS;
  localparam int NB = rlb_pkg::NUM_BITS;
  localparam int PB = KB + 1;

  // stage b: first products
  logic [TB-1:0] tc;
  logic          szero;
  rlb_pkg::chan_t sv;
  logic [PB-1:0] p1_full;
  logic [PB-1:0] p2_full;
  logic [PB-1:0] p3_full;
  logic [PB-1:0] k_full;

  rlb_pkg::chan_t     d_b;
  rlb_pkg::chan_t     s_b;
  logic               szero_b;
  rlb_pkg::lane_ctl_t ctl_b;
  logic [KB-1:0]      p1_b;
  logic [KB-1:0]      p2_b;
  logic [KB-1:0]      k_b;

  assign tc    = rlb_pkg::T_ONE - t;
  assign szero = (s == '0);
  // divide by a zero source channel becomes a lerp towards full or zero
  assign sv    = ((ctl.mode == rlb_pkg::MODE_DIV) && szero) ?
                 ((d != '0) ? rlb_pkg::CH_MAX : '0) : s;

  assign p1_full = PB'(d) * PB'(tc);
  assign p2_full = PB'(sv) * PB'(t);
  assign p3_full = PB'(s) * PB'(tc);
  assign k_full  = (ctl.mode == rlb_pkg::MODE_MUL) ?
                   ({tc, {CB{1'b0}}} - PB'(tc) + p2_full) :
                   (p3_full + {t, {CB{1'b0}}} - PB'(t));

  always_ff @(posedge clk) begin
    d_b     <= d;
    s_b     <= s;
    szero_b <= szero;
    ctl_b   <= ctl;
    p1_b    <= p1_full[KB-1:0];
    p2_b    <= p2_full[KB-1:0];
    k_b     <= k_full[KB-1:0];
  end

  // stage c: linear modes and the wide products
  logic [PB-1:0]  lerp_sum;
  logic [PB-1:0]  add_sum;
  logic [KB-1:0]  d_sh;
  logic [KB-1:0]  sub_diff;
  rlb_pkg::chan_t lin;
  logic [KB-1:0]  ka;
  logic [KB-1:0]  kb;
  logic [NB-1:0]  pa;
  logic [NB-1:0]  pb;

  rlb_pkg::chan_t     lin_c;
  logic [NB-1:0]      pa_c;
  logic [NB-1:0]      pb_c;
  rlb_pkg::chan_t     d_c;
  rlb_pkg::chan_t     s_c;
  logic               szero_c;
  rlb_pkg::lane_ctl_t ctl_c;

  assign lerp_sum = PB'(p1_b) + PB'(p2_b);
  assign d_sh     = {d_b, {CB{1'b0}}};
  assign add_sum  = PB'(d_sh) + PB'(p2_b);
  assign sub_diff = d_sh - p2_b;

  always_comb begin
    case (ctl_b.mode)
      rlb_pkg::MODE_ADD: begin
        lin = add_sum[KB] ? rlb_pkg::CH_MAX : add_sum[KB-1:CB];
      end
      rlb_pkg::MODE_SUB: begin
        lin = (d_sh <= p2_b) ? '0 : sub_diff[KB-1:CB];
      end
      default: begin
        lin = lerp_sum[KB-1:CB];
      end
    endcase
  end

  assign ka = (ctl_b.mode == rlb_pkg::MODE_ALPHA) ? wc : k_b;
  assign kb = (ctl_b.mode == rlb_pkg::MODE_ALPHA) ? w : '0;
  assign pa = NB'(d_b) * NB'(ka);
  assign pb = NB'(s_b) * NB'(kb);

  always_ff @(posedge clk) begin
    lin_c   <= lin;
    pa_c    <= pa;
    pb_c    <= pb;
    d_c     <= d_b;
    s_c     <= s_b;
    szero_c <= szero_b;
    ctl_c   <= ctl_b;
  end

  // stage d: numerator, scaled down by 256
  logic [NB-1:0] num;

  logic [KB-1:0]      y_d;
  rlb_pkg::chan_t     lin_d;
  rlb_pkg::chan_t     d_d;
  rlb_pkg::chan_t     s_d;
  logic               szero_d;
  rlb_pkg::lane_ctl_t ctl_d;

  assign num = pa_c + pb_c;

  always_ff @(posedge clk) begin
    y_d     <= num[NB-1:CB];
    lin_d   <= lin_c;
    d_d     <= d_c;
    s_d     <= s_c;
    szero_d <= szero_c;
    ctl_d   <= ctl_c;
  end

  // stage e: divide by 255 by estimate and correction, divider runs alongside
  logic [CB:0]    r255;
  rlb_pkg::chan_t q255;
  rlb_pkg::chan_t qdiv;

  rlb_pkg::chan_t     q255_e;
  rlb_pkg::chan_t     lin_e;
  rlb_pkg::chan_t     d_e;
  logic               szero_e;
  rlb_pkg::lane_ctl_t ctl_e;

  assign r255 = (CB + 1)'(y_d[CB-1:0]) + (CB + 1)'(y_d[KB-1:CB]);

  always_comb begin
    if (r255 >= (CB + 1)'(2 * 255)) begin
      q255 = y_d[KB-1:CB] + CB'(2);
    end else if (r255 >= (CB + 1)'(255)) begin
      q255 = y_d[KB-1:CB] + CB'(1);
    end else begin
      q255 = y_d[KB-1:CB];
    end
  end

  rlb_div u_div (
    .clk  (clk),
    .num  (y_d),
    .den  (s_d),
    .quot (qdiv)
  );

  always_ff @(posedge clk) begin
    q255_e  <= q255;
    lin_e   <= lin_d;
    d_e     <= d_d;
    szero_e <= szero_d;
    ctl_e   <= ctl_d;
  end

  // output register
  rlb_pkg::chan_t value_next;

  always_comb begin
    if (ctl_e.pass) begin
      value_next = d_e;
    end else begin
      case (ctl_e.mode)
        rlb_pkg::MODE_LERP,
        rlb_pkg::MODE_ADD,
        rlb_pkg::MODE_SUB: begin
          value_next = lin_e;
        end
        rlb_pkg::MODE_MUL,
        rlb_pkg::MODE_ALPHA: begin
          value_next = q255_e;
        end
        rlb_pkg::MODE_DIV: begin
          value_next = szero_e ? lin_e : qdiv;
        end
        default: begin
          value_next = d_e;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

[rtl/rgba8_layer_blend_unit.sv]
`default_nettype none

// channel   | signals                              | transfer
// ----------+--------------------------------------+-------------------------------
// pixel in  | start, busy, item                    | edge with start high, busy low
// result    | result_strobe, result                | every strobed cycle, no stall
// config    | cfg_wr_en, cfg_index, cfg_data       | edge with cfg_wr_en high
//
// a pixel can be taken every cycle; busy is never raised
// each result appears in order, registered through stage a, lane stages b to e and the output register
// the lanes hold the product, numerator and two-stage divider pipeline
// rst clears the valid pipeline and loads the register defaults
// the result side cannot stall, so the pipeline never holds

module rgba8_layer_blend_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire rlb_pkg::pixel_in_t                  item,
  output logic                                     result_strobe,
  output rlb_pkg::pixel_out_t                      result,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rlb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [rlb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB    = rlb_pkg::CHANNEL_BITS;
  localparam int TB    = rlb_pkg::T_BITS;
  localparam int KB    = rlb_pkg::K_BITS;
  localparam int NCH   = rlb_pkg::NUM_CHANNELS;
  localparam int DEPTH = 5;

  // configuration registers
  logic [2:0]     blend_mode;
  logic [TB-1:0]  transparency;
  rlb_pkg::chan_t color_red;
  rlb_pkg::chan_t color_green;
  rlb_pkg::chan_t color_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= rlb_pkg::MODE_ADD;
      transparency <= rlb_pkg::T_ONE;
      color_red    <= rlb_pkg::CH_MAX;
      color_green  <= rlb_pkg::CH_MAX;
      color_blue   <= rlb_pkg::CH_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rlb_pkg::REG_MODE:  blend_mode   <= cfg_data[2:0];
        rlb_pkg::REG_TRANS: transparency <= cfg_data;
        rlb_pkg::REG_RED:   color_red    <= cfg_data[CB-1:0];
        rlb_pkg::REG_GREEN: color_green  <= cfg_data[CB-1:0];
        rlb_pkg::REG_BLUE:  color_blue   <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage a: capture, layer colour substitution, opacity clamp
  rlb_pkg::chan_t d_a [NCH];
  rlb_pkg::chan_t s_a [NCH];
  logic [TB-1:0]  t_a;
  logic [2:0]     mode_a;
  logic           valid_a;

  always_ff @(posedge clk) begin
    d_a[0] <= item.dest_red;
    d_a[1] <= item.dest_green;
    d_a[2] <= item.dest_blue;
    d_a[3] <= item.dest_alpha;
    if (item.src_present) begin
      s_a[0] <= item.src_red;
      s_a[1] <= item.src_green;
      s_a[2] <= item.src_blue;
      s_a[3] <= item.src_alpha;
    end else begin
      s_a[0] <= color_red;
      s_a[1] <= color_green;
      s_a[2] <= color_blue;
      s_a[3] <= rlb_pkg::CH_MAX;
    end
    t_a    <= transparency[TB-1] ? rlb_pkg::T_ONE : transparency;
    mode_a <= blend_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= accept;
    end
  end

  // alpha weight shared by the colour lanes, aligned with stage b
  logic [KB:0]   w_full;
  logic [KB-1:0] w_b;
  logic [KB-1:0] wc_b;

  assign w_full = (KB + 1)'(t_a) * (KB + 1)'(s_a[NCH-1]);

  always_ff @(posedge clk) begin
    w_b  <= w_full[KB-1:0];
    wc_b <= rlb_pkg::W_ONE - w_full[KB-1:0];
  end

  // valid bits follow the lanes
  logic [DEPTH-1:0] valid_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[DEPTH-2:0], valid_a};
    end
  end

  assign result_strobe = valid_pipe[DEPTH-1];

  rlb_pkg::chan_t lane_out [NCH];

  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    rlb_pkg::lane_ctl_t ctl;

    // alpha keeps the destination in source-alpha mode
    assign ctl.mode = mode_a;
    assign ctl.pass = (ch == NCH - 1) ? (mode_a >= rlb_pkg::MODE_ALPHA) :
                                        (mode_a >  rlb_pkg::MODE_ALPHA);

    rlb_chan u_chan (
      .clk   (clk),
      .d     (d_a[ch]),
      .s     (s_a[ch]),
      .t     (t_a),
      .ctl   (ctl),
      .w     (w_b),
      .wc    (wc_b),
      .value (lane_out[ch])
    );
  end

  assign result.out_red   = lane_out[0];
  assign result.out_green = lane_out[1];
  assign result.out_blue  = lane_out[2];
  assign result.out_alpha = lane_out[3];

endmodule

`default_nettype wire

[tb/rgba8_layer_blend_unit_tb.sv]
module rgba8_layer_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UNITY          = 256;
  localparam int unsigned FULL_WEIGHT    = 65280;
  localparam int unsigned CHAN_TOP       = 255;
  localparam int          RESULT_LATENCY = 6;
  localparam int          STALL_LIMIT    = 4000;
  localparam int          RANDOM_CONFIGS = 7;
  localparam int          PIXELS_PER_CFG = 84;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  rlb_pkg::pixel_in_t                  pixel_item = '0;
  logic                                result_strobe;
  rlb_pkg::pixel_out_t                 blended;
  logic                                cfg_wr_en = 1'b0;
  logic [rlb_pkg::CFG_INDEX_BITS-1:0]  cfg_index = rlb_pkg::REG_MODE;
  logic [rlb_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

  // shadow of the layer registers, loaded with the reset values
  logic [2:0]     blend_mode_reg = rlb_pkg::MODE_ADD;
  logic [8:0]     trans_reg      = 9'd256;
  rlb_pkg::chan_t layer_red      = 8'hff;
  rlb_pkg::chan_t layer_green    = 8'hff;
  rlb_pkg::chan_t layer_blue     = 8'hff;

  rlb_pkg::pixel_out_t expected_pixels[$];
  rlb_pkg::pixel_out_t want;
  int                  mismatches = 0;
  int                  sender_idle_pct = 0;
  int                  quiet_cycles;

  rgba8_layer_blend_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (pixel_item),
    .result_strobe (result_strobe),
    .result        (blended),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_chan(int unsigned v);
    return (v > CHAN_TOP) ? CHAN_TOP : v;
  endfunction

  function automatic int unsigned blend_channel(logic [2:0] mode, int unsigned d,
                                                int unsigned s, int unsigned t);
    int unsigned q;
    case (mode)
      rlb_pkg::MODE_LERP: return clamp_chan((d * (UNITY - t) + s * t) / UNITY);
      rlb_pkg::MODE_ADD:  return clamp_chan((d * UNITY + s * t) / UNITY);
      rlb_pkg::MODE_SUB: begin
        if (d * UNITY <= s * t) return 0;
        return clamp_chan((d * UNITY - s * t) / UNITY);
      end
      rlb_pkg::MODE_MUL: begin
        return clamp_chan((d * CHAN_TOP * (UNITY - t) + d * s * t) / FULL_WEIGHT);
      end
      rlb_pkg::MODE_DIV: begin
        // zero divisor: full scale unless the destination is black too
        if (s == 0) begin
          q = (d != 0) ? CHAN_TOP : 0;
          return clamp_chan((d * (UNITY - t) + q * t) / UNITY);
        end
        return clamp_chan((d * s * (UNITY - t) + d * CHAN_TOP * t) / (s * UNITY));
      end
      default:   return d;
    endcase
  endfunction

  function automatic rlb_pkg::pixel_out_t blend_pixel(rlb_pkg::pixel_in_t px);
    int unsigned         dst[4];
    int unsigned         src[4];
    int unsigned         mix[4];
    int unsigned         t;
    int unsigned         w;
    rlb_pkg::pixel_out_t o;
    t   = (trans_reg > UNITY) ? UNITY : trans_reg;
    dst = '{px.dest_red, px.dest_green, px.dest_blue, px.dest_alpha};
    if (px.src_present) begin
      src = '{px.src_red, px.src_green, px.src_blue, px.src_alpha};
    end else begin
      src = '{layer_red, layer_green, layer_blue, CHAN_TOP};
    end
    if (blend_mode_reg == rlb_pkg::MODE_ALPHA) begin
      w = t * src[3];
      for (int i = 0; i < 3; i++) begin
        mix[i] = clamp_chan((dst[i] * (FULL_WEIGHT - w) + src[i] * w) / FULL_WEIGHT);
      end
      mix[3] = dst[3];
    end else begin
      for (int i = 0; i < 4; i++) begin
        mix[i] = blend_channel(blend_mode_reg, dst[i], src[i], t);
      end
    end
    o.out_red   = rlb_pkg::chan_t'(mix[0]);
    o.out_green = rlb_pkg::chan_t'(mix[1]);
    o.out_blue  = rlb_pkg::chan_t'(mix[2]);
    o.out_alpha = rlb_pkg::chan_t'(mix[3]);
    return o;
  endfunction

  function automatic rlb_pkg::chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return rlb_pkg::chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input rlb_pkg::chan_t got,
                                 input rlb_pkg::chan_t exp_val);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  // one pixel transfer; start stays high on return so back-to-back pixels never drop it
  task automatic send_pixel(input rlb_pkg::pixel_in_t px);
    bit stalled;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    pixel_item <= px;
    stalled = 1'b1;
    while (stalled) begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end
    expected_pixels.push_back(blend_pixel(px));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlb_pkg::CFG_INDEX_BITS-1:0] idx,
                           input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rlb_pkg::CFG_DATA_BITS'(val);
    @(posedge clk);
    case (idx)
      rlb_pkg::REG_MODE:  blend_mode_reg = 3'(val);
      rlb_pkg::REG_TRANS: trans_reg      = 9'(val);
      rlb_pkg::REG_RED:   layer_red      = rlb_pkg::chan_t'(val);
      rlb_pkg::REG_GREEN: layer_green    = rlb_pkg::chan_t'(val);
      rlb_pkg::REG_BLUE:  layer_blue     = rlb_pkg::chan_t'(val);
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [2:0] mode, input int unsigned trans,
                              input rlb_pkg::chan_t r, input rlb_pkg::chan_t g,
                              input rlb_pkg::chan_t b);
    write_reg(rlb_pkg::REG_MODE, mode);
    write_reg(rlb_pkg::REG_TRANS, trans);
    write_reg(rlb_pkg::REG_RED, r);
    write_reg(rlb_pkg::REG_GREEN, g);
    write_reg(rlb_pkg::REG_BLUE, b);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel('{dest_red: 8'h10, dest_green: 8'hf0, dest_blue: 8'h00, dest_alpha: 8'h80,
                 src_present: 1'b0, src_red: 8'h12, src_green: 8'h34, src_blue: 8'h56,
                 src_alpha: 8'h78});
  endtask

  task automatic test_directed_modes();
    int unsigned trans_pick[8];
    logic [2:0]  mode;
    trans_pick = '{0, 256, 511, 128, 1, 257, 255, 0};
    for (int m = 0; m < 8; m++) begin
      mode = 3'(m);
      drain_results();
      write_config(mode, trans_pick[m], (m % 2) ? 8'hff : 8'h00, 8'hff, 8'h4d);
      // zero source against full and zero destination exercises the divide special case
      send_pixel('{dest_red: 8'hff, dest_green: 8'h00, dest_blue: 8'h80, dest_alpha: 8'h01,
                   src_present: 1'b1, src_red: 8'h00, src_green: 8'h00, src_blue: 8'hff,
                   src_alpha: 8'hff});
      send_pixel('{dest_red: 8'h00, dest_green: 8'hff, dest_blue: 8'h00, dest_alpha: 8'hff,
                   src_present: 1'b1, src_red: 8'hff, src_green: 8'hff, src_blue: 8'h00,
                   src_alpha: 8'h00});
      // layer colour replaces the source, its channels are don't-care
      send_pixel('{dest_red: 8'hc8, dest_green: 8'h11, dest_blue: 8'hff, dest_alpha: 8'h00,
                   src_present: 1'b0, src_red: 8'h5a, src_green: 8'ha5, src_blue: 8'h00,
                   src_alpha: 8'hff});
    end
  endtask

  task automatic test_random_traffic(input int idle_pct);
    int unsigned        trans;
    rlb_pkg::pixel_in_t px;
    sender_idle_pct = idle_pct;
    for (int c = 0; c < RANDOM_CONFIGS; c++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       trans = 0;
        1:       trans = UNITY;
        2:       trans = $urandom_range(257, 511);
        default: trans = $urandom_range(0, 256);
      endcase
      write_config(3'($urandom_range(0, 7)), trans, rand_chan(), rand_chan(), rand_chan());
      repeat (PIXELS_PER_CFG) begin
        px.dest_red    = rand_chan();
        px.dest_green  = rand_chan();
        px.dest_blue   = rand_chan();
        px.dest_alpha  = rand_chan();
        px.src_present = ($urandom_range(0, 3) != 0);
        px.src_red     = rand_chan();
        px.src_green   = rand_chan();
        px.src_blue    = rand_chan();
        px.src_alpha   = rand_chan();
        send_pixel(px);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", blended.out_red, 8'h00);
      end else begin
        want = expected_pixels.pop_front();
        if (blended.out_red !== want.out_red)
          report_mismatch("out_red", blended.out_red, want.out_red);
        if (blended.out_green !== want.out_green)
          report_mismatch("out_green", blended.out_green, want.out_green);
        if (blended.out_blue !== want.out_blue)
          report_mismatch("out_blue", blended.out_blue, want.out_blue);
        if (blended.out_alpha !== want.out_alpha)
          report_mismatch("out_alpha", blended.out_alpha, want.out_alpha);
      end
    end
  end

  // cycles with no transfer on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (start && !busy) || result_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_modes();
    test_random_traffic(37);
    test_random_traffic(69);
    test_random_traffic(0);
    drain_results();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
